FILE: src/embedding_bag_aggregate_top_defines.svh
// ---------------------------------------------------------------------------
// embedding_bag_aggregate_top_defines: assertion macros
// short forms for the concurrent checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef EMBEDDING_BAG_AGGREGATE_TOP_DEFINES_SVH
`define EMBEDDING_BAG_AGGREGATE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define EBA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define EBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/eba_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eba_pkg: shared types and constants of the embedding bag aggregator
// payload structs, mode and register codes, widths
// ---------------------------------------------------------------------------
package eba_pkg;

   localparam int unsigned MAX_COLS_DEF    = 64;    // range 1 .. 64, set by the column field
   localparam int unsigned MAX_BAG_ROWS    = 65536;
   localparam int unsigned ROWS_W          = 17;
   localparam int unsigned COL_W           = 6;
   localparam int unsigned VAL_W           = 16;
   localparam int unsigned ACC_W           = 32;
   localparam int unsigned MODE_W          = 2;
   localparam int unsigned CFG_W           = 7;
   localparam int unsigned CSR_IDX_W       = 1;
   localparam int unsigned QUEUE_DEPTH     = 2;     // power of two
   localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 7'd64;

   localparam logic [MODE_W-1:0] MODE_SUM  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MEAN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MAX  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_POOL_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_WIDTH = 1'b1;

   typedef struct packed {
      logic signed [VAL_W-1:0] elem_value;
      logic [COL_W-1:0]        elem_col;
      logic                    final_row;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] pooled_value;
      logic [COL_W-1:0]        pooled_col;
      logic                    bag_done;
      logic [ROWS_W-1:0]       bag_rows;
   } rsp_type;

   typedef struct packed {
      logic [MODE_W-1:0] pool_mode;
      logic [CFG_W-1:0]  row_width;
   } cfg_type;

   // classified element handed from front to back
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [COL_W-1:0]        col;
      logic                    final_row;
      logic                    last_col;
   } work_type;

   typedef struct packed {
      logic idle;
      logic div_busy;
      logic bag_clear;
      logic rows_zero;
   } bk_status_type;

endpackage

FILE: src/eba_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eba_ram: generic single-write, single-read memory
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module eba_ram #(
   parameter int unsigned WIDTH = eba_pkg::ACC_W,
   parameter int unsigned DEPTH = eba_pkg::MAX_COLS_DEF
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/eba_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eba_div: iterative signed divider for the mean
// restoring division, one quotient bit per cycle, truncates toward zero
// ---------------------------------------------------------------------------
module eba_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [eba_pkg::ACC_W-1:0]   dividend,
   input  logic [eba_pkg::ROWS_W-1:0]         divisor,
   output logic                               busy,
   output logic                               done,
   output logic signed [eba_pkg::ACC_W-1:0]   quotient
);
   import eba_pkg::*;

   localparam int unsigned STEP_W = $clog2(ACC_W);

   logic                busy_ff, done_ff, neg_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [ROWS_W-1:0]   rem_ff, dvs_ff;
   logic [ACC_W-1:0]    quo_ff;
   logic [ACC_W-1:0]    dividend_mag;
   logic [ROWS_W:0]     trial, diff;
   logic                fits;

   assign dividend_mag = dividend[ACC_W-1] ? (~dividend + ACC_W'(1)) : dividend;
   assign trial        = {rem_ff, quo_ff[ACC_W-1]};
   assign diff         = trial - {1'b0, dvs_ff};
   assign fits         = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (step_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend_mag;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
         neg_ff  <= dividend[ACC_W-1];
         step_ff <= STEP_W'(ACC_W - 1);
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[ROWS_W-1:0] : trial[ROWS_W-1:0];
         quo_ff  <= {quo_ff[ACC_W-2:0], fits};
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? signed'(~quo_ff + ACC_W'(1)) : signed'(quo_ff);

endmodule

FILE: src/eba_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eba_front: element intake and classification
// drops out-of-range columns, marks the last column, queues work for the back
// ---------------------------------------------------------------------------
module eba_front #(
   parameter int unsigned MAX_COLS = eba_pkg::MAX_COLS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  eba_pkg::req_type  req,
   input  eba_pkg::cfg_type  cfg,
   output logic              wk_valid,
   input  logic              wk_ready,
   output eba_pkg::work_type wk
);
   import eba_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CFG_W-1:0]  width_used;
   logic              in_range, push, pop;
   work_type          entry;

   // row width clamped to 1 .. MAX_COLS
   always_comb begin
      priority if (cfg.row_width == '0) begin
         width_used = CFG_W'(1);
      end else if (cfg.row_width > CFG_W'(MAX_COLS)) begin
         width_used = CFG_W'(MAX_COLS);
      end else begin
         width_used = cfg.row_width;
      end
   end

   assign in_range = {1'b0, req.elem_col} < width_used;

   always_comb begin
      entry.value     = req.elem_value;
      entry.col       = req.elem_col;
      entry.final_row = req.final_row;
      entry.last_col  = {1'b0, req.elem_col} == (width_used - CFG_W'(1));
   end

   assign req_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign push      = req_valid && req_ready && in_range;
   assign pop       = wk_valid && wk_ready;
   assign wk_valid  = count_ff != '0;
   assign wk        = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

FILE: src/eba_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eba_back: accumulation and result engine
// read-modify-write of the column accumulators, mean division, result register
// ---------------------------------------------------------------------------
module eba_back #(
   parameter int unsigned MAX_COLS = eba_pkg::MAX_COLS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wk_valid,
   output logic                   wk_ready,
   input  eba_pkg::work_type      wk,
   input  eba_pkg::cfg_type       cfg,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output eba_pkg::rsp_type       rsp,
   output eba_pkg::bk_status_type status
);
   import eba_pkg::*;

   localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_DIV  = 4'b0100,
      S_OUT  = 4'b1000
   } bk_state_type;

   bk_state_type            state_ff, state_in;
   work_type                item_ff;
   logic [ROWS_W-1:0]       rows_seen_ff, count_ff, count_in;
   logic [MAX_COLS-1:0]     valid_ff;
   logic signed [ACC_W-1:0] res_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic [AW-1:0]           cur_addr;
   logic [ACC_W-1:0]        ram_rdata;
   logic signed [ACC_W-1:0] acc_old, val_ext, sat_sum, new_acc, div_quot;
   logic [ACC_W:0]          sum_wide;
   logic                    rows_zero, take_new, in_read, pop, div_start;
   logic                    div_busy, div_done, load_rsp, bag_clear, row_end;

   assign wk_ready  = state_ff == S_IDLE;
   assign pop       = wk_valid && wk_ready;
   assign in_read   = state_ff == S_READ;
   assign cur_addr  = item_ff.col[AW-1:0];
   assign rows_zero = rows_seen_ff == '0;

   eba_ram #(
      .WIDTH (ACC_W),
      .DEPTH (MAX_COLS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (in_read),
      .wr_addr (cur_addr),
      .wr_data (new_acc),
      .rd_en   (pop),
      .rd_addr (wk.col[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // entries untouched since the last bag end read as zero
   assign acc_old  = valid_ff[cur_addr] ? signed'(ram_rdata) : '0;
   assign val_ext  = {{(ACC_W - VAL_W){item_ff.value[VAL_W-1]}}, item_ff.value};
   assign sum_wide = {acc_old[ACC_W-1], acc_old} + {val_ext[ACC_W-1], val_ext};
   assign take_new = rows_zero || (val_ext > acc_old);

   always_comb begin
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         sat_sum = sum_wide[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                   : {1'b0, {(ACC_W - 1){1'b1}}};
      end else begin
         sat_sum = sum_wide[ACC_W-1:0];
      end
   end

   always_comb begin
      unique case (cfg.pool_mode)
         MODE_SUM, MODE_MEAN: new_acc = sat_sum;
         MODE_MAX:            new_acc = take_new ? val_ext : acc_old;
         default:             new_acc = sat_sum;
      endcase
   end

   assign count_in  = rows_seen_ff + ROWS_W'(1);
   assign row_end   = in_read && !item_ff.final_row && item_ff.last_col
                      && (rows_seen_ff < ROWS_W'(MAX_BAG_ROWS - 1));
   assign div_start = in_read && item_ff.final_row && (cfg.pool_mode == MODE_MEAN);
   assign load_rsp  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign bag_clear = load_rsp && item_ff.last_col;

   eba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (new_acc),
      .divisor  (count_in),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (wk_valid) state_in = S_READ;
         end
         S_READ: begin
            if (!item_ff.final_row) begin
               state_in = S_IDLE;
            end else if (cfg.pool_mode == MODE_MEAN) begin
               state_in = S_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            if (div_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (load_rsp) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_seen_ff <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (bag_clear) begin
            valid_ff     <= '0;
            rows_seen_ff <= '0;
         end else begin
            if (in_read) valid_ff[cur_addr] <= 1'b1;
            if (row_end) rows_seen_ff <= count_in;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= wk;
      end
      if (in_read) begin
         count_ff <= count_in;
         res_ff   <= new_acc;
      end else if ((state_ff == S_DIV) && div_done) begin
         res_ff <= div_quot;
      end
      if (load_rsp) begin
         rsp_ff.pooled_value <= res_ff;
         rsp_ff.pooled_col   <= item_ff.col;
         rsp_ff.bag_done     <= item_ff.last_col;
         rsp_ff.bag_rows     <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      status.idle      = state_ff == S_IDLE;
      status.div_busy  = div_busy;
      status.bag_clear = bag_clear;
      status.rows_zero = rows_zero;
   end

endmodule

FILE: src/embedding_bag_aggregate_top.sv
// path: a final-row element in sum or max mode goes through the read and output states and the
//   response register to rsp; in mean mode the bit-serial divider state lies between read and output
// occupancy: the accumulator engine takes a new element only once the last one is through and it
//   is back in idle; out-of-range columns are dropped on intake
// reset: synchronous active high; clears queue, state, row count and accumulator valid bits
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// embedding_bag_aggregate_top: column-wise pooling of embedding rows into bags
// sum, mean or max per column over the rows of a bag, one result per final-row element
// ---------------------------------------------------------------------------
`include "embedding_bag_aggregate_top_defines.svh"

module embedding_bag_aggregate_top #(
   parameter int unsigned MAX_COLS = eba_pkg::MAX_COLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // element input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  eba_pkg::req_type                  req,
   // pooled result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output eba_pkg::rsp_type                  rsp,
   // register write port
   input  logic                              csr_wr_en,
   input  logic [eba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [eba_pkg::CFG_W-1:0]         csr_wdata
);
   import eba_pkg::*;

   // configuration registers; to be written only while no bag is in flight, which the block does not enforce
   logic [MODE_W-1:0] pool_mode_ff;
   logic [CFG_W-1:0]  row_width_ff;
   cfg_type           cfg;

   // front to back work queue transfer
   logic              wk_valid, wk_ready;
   work_type          wk;
   bk_status_type     bk_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_mode_ff <= MODE_SUM;
         row_width_ff <= ROW_WIDTH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_POOL_MODE: pool_mode_ff <= csr_wdata[MODE_W-1:0];
            REG_ROW_WIDTH: row_width_ff <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      cfg.pool_mode = pool_mode_ff;
      cfg.row_width = row_width_ff;
   end

   // intake: clamps the row width, classifies each element, queues it
   eba_front #(
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .cfg       (cfg),
      .wk_valid  (wk_valid),
      .wk_ready  (wk_ready),
      .wk        (wk)
   );

   // engine: accumulator memory read-modify-write, mean divide, result register
   eba_back #(
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .wk_valid  (wk_valid),
      .wk_ready  (wk_ready),
      .wk        (wk),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .status    (bk_status)
   );

   // a pooled result always covers at least the final row
   `EBA_ASSERT_IMPLY(a_rows_nonzero, clock, reset, rsp_valid, rsp.bag_rows != '0,
                     "bag_rows is zero on a valid result")

   // the end of a bag leaves the row count cleared for the next bag
   `EBA_ASSERT_NEXT(a_bag_clear_rows, clock, reset, bk_status.bag_clear, bk_status.rows_zero,
                    "row count not cleared after bag end")

   // the divider only runs while the engine is occupied with a mean result
   `EBA_ASSERT_IMPLY(a_div_owned, clock, reset, bk_status.div_busy, !bk_status.idle,
                     "divider busy while engine idle")

endmodule
